### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ITRS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("integer_to_radix_symbols assertion failed");

// Clocked assertion that stays active during reset.
`define ITRS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("integer_to_radix_symbols reset assertion failed");

`endif

### rtl/itrs_pkg.sv
// ----------------------------------------------------------------------------
// itrs_pkg
// Shared types, constants and the symbol table lookup for the radix converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itrs_pkg;

    localparam int MAX_SYMBOLS = 16;

    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_MINUS = 8'h2D;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SYMBOL_COUNT = 2'd0,
        CFG_SYMBOLS_LOW  = 2'd1,
        CFG_SYMBOLS_HIGH = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_CHECK  = 2'd1,
        ST_DIVIDE = 2'd2,
        ST_EMIT   = 2'd3
    } t_state;

    // Pick symbol idx out of the two packed table words.
    function automatic logic [7:0] itrs_sym(input logic [63:0] lo,
                                            input logic [63:0] hi,
                                            input logic [3:0]  idx);
        logic [63:0] w;
        w = idx[3] ? hi : lo;
        return w[{idx[2:0], 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

### rtl/integer_to_radix_symbols_core.sv
// ----------------------------------------------------------------------------
// integer_to_radix_symbols_core
// Signed 32-bit integer to text in a configurable radix, one symbol per beat.
// ----------------------------------------------------------------------------
// A number is taken as one input beat and comes out as a run of symbol beats,
// most significant digit first, with a leading '-' for negative values and
// o_last set on the final digit. The radix is the symbol count register, and
// the digits are taken from the sixteen-entry symbol table. An unusable base
// (fewer than two symbols, more than sixteen, a symbol that is zero, '+' or
// '-', or a repeated symbol) makes the block drop the number without output.
// The block works on one number at a time and holds o_stall high meanwhile.
// After the number is taken, the base check walks one table entry per cycle,
// the shared divider retires eight quotient bits per cycle to find each
// digit, and the digit buffer then drains one symbol per cycle while the
// output is not stalled, after the minus sign when there is one.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_symbols_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Configuration write port.
    input  wire                                i_cfg_we,
    input  wire [itrs_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire [itrs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Number input channel.
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire signed [31:0]                  i_number,
    // Symbol output channel.
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic [7:0]                         o_symbol,
    output logic                               o_last
);

    import itrs_pkg::*;

    // Configuration registers.
    logic [4:0]  r_symbol_count;
    logic [63:0] r_symbols_low;
    logic [63:0] r_symbols_high;

    // Sequencer and datapath registers.
    t_state      r_state, n_state;
    logic        r_neg, n_neg;          // a minus sign is still to be sent
    logic [3:0]  r_idx, n_idx;          // table entry under check
    logic [31:0] r_quot, n_quot;        // dividend, becomes the quotient
    logic [4:0]  r_rem, n_rem;          // partial remainder
    logic [1:0]  r_chunk, n_chunk;      // which byte of the dividend is in work
    logic [5:0]  r_nd, n_nd;            // digits found so far
    logic [4:0]  r_ptr, n_ptr;          // digit being sent
    logic [3:0]  r_dig [32];            // digit values, least significant first
    logic        n_dig_we;

    // Output register.
    logic        r_o_valid, n_o_valid;
    logic [7:0]  r_o_symbol, n_o_symbol;
    logic        r_o_last, n_o_last;

    logic        in_beat;
    logic        out_load;
    logic [7:0]  check_sym;
    logic        check_bad;
    logic        count_bad;
    logic [4:0]  step_rem;
    logic [31:0] step_quot;

    assign o_stall  = (r_state != ST_IDLE);
    assign in_beat  = i_valid && !o_stall;
    assign out_load = !r_o_valid || !i_stall;

    assign o_valid  = r_o_valid;
    assign o_symbol = r_o_symbol;
    assign o_last   = r_o_last;

    // Base check: one table entry against the forbidden bytes and against
    // every later entry in use, all combinationally.
    assign count_bad = (r_symbol_count < 5'd2) || (r_symbol_count > 5'(MAX_SYMBOLS));
    assign check_sym = itrs_sym(r_symbols_low, r_symbols_high, r_idx);

    always_comb begin : base_check
        logic bad;
        bad = (check_sym == 8'h00) || (check_sym == SYM_PLUS) || (check_sym == SYM_MINUS);
        for (int b = 0; b < MAX_SYMBOLS; b++) begin
            if ((4'(b) > r_idx) && (5'(b) < r_symbol_count) &&
                (itrs_sym(r_symbols_low, r_symbols_high, 4'(b)) == check_sym)) begin
                bad = 1'b1;
            end
        end
        check_bad = bad;
    end

    // Shared divider: eight restoring steps by the radix per cycle.
    always_comb begin : div_step
        logic [4:0]  rem;
        logic [31:0] q;
        rem = r_rem;
        q   = r_quot;
        for (int j = 0; j < 8; j++) begin
            rem = {rem[3:0], q[31]};
            q   = {q[30:0], (rem >= r_symbol_count)};
            if (q[0]) begin
                rem = rem - r_symbol_count;
            end
        end
        step_rem  = rem;
        step_quot = q;
    end

    // Next state and datapath control.
    always_comb begin
        n_state    = r_state;
        n_neg      = r_neg;
        n_idx      = r_idx;
        n_quot     = r_quot;
        n_rem      = r_rem;
        n_chunk    = r_chunk;
        n_nd       = r_nd;
        n_ptr      = r_ptr;
        n_dig_we   = 1'b0;
        n_o_valid  = r_o_valid && i_stall;
        n_o_symbol = r_o_symbol;
        n_o_last   = r_o_last;

        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_neg   = i_number[31];
                    n_quot  = i_number[31] ? (32'd0 - $unsigned(i_number))
                                           : $unsigned(i_number);
                    n_idx   = 4'd0;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (count_bad || check_bad) begin
                    n_state = ST_IDLE;
                end else if ({1'b0, r_idx} == (r_symbol_count - 5'd1)) begin
                    n_rem   = 5'd0;
                    n_chunk = 2'd0;
                    n_nd    = 6'd0;
                    n_state = ST_DIVIDE;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            ST_DIVIDE: begin
                n_quot  = step_quot;
                n_rem   = step_rem;
                n_chunk = r_chunk + 2'd1;
                if (r_chunk == 2'd3) begin
                    // The quotient is complete and the remainder is a digit.
                    n_dig_we = 1'b1;
                    n_nd     = r_nd + 6'd1;
                    n_rem    = 5'd0;
                    if ((step_quot == 32'd0) || (r_nd == 6'd31)) begin
                        n_ptr   = r_nd[4:0];
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_o_valid = 1'b1;
                    if (r_neg) begin
                        n_neg      = 1'b0;
                        n_o_symbol = SYM_MINUS;
                        n_o_last   = 1'b0;
                    end else begin
                        n_o_symbol = itrs_sym(r_symbols_low, r_symbols_high, r_dig[r_ptr]);
                        n_o_last   = (r_ptr == 5'd0);
                        if (r_ptr == 5'd0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_ptr = r_ptr - 5'd1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration registers; a write to the unused index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= 5'd0;
            r_symbols_low  <= 64'd0;
            r_symbols_high <= 64'd0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SYMBOL_COUNT: r_symbol_count <= i_cfg_data[4:0];
                CFG_SYMBOLS_LOW:  r_symbols_low  <= i_cfg_data;
                CFG_SYMBOLS_HIGH: r_symbols_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // State register and the output beat valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_idx      <= n_idx;
        r_quot     <= n_quot;
        r_rem      <= n_rem;
        r_chunk    <= n_chunk;
        r_nd       <= n_nd;
        r_ptr      <= n_ptr;
        r_o_symbol <= n_o_symbol;
        r_o_last   <= n_o_last;
    end

    // Digit buffer.
    always_ff @(posedge i_clk) begin
        if (n_dig_we) begin
            r_dig[r_nd[4:0]] <= step_rem[3:0];
        end
    end

endmodule

`default_nettype wire

### rtl/itrs_checker.sv
// ----------------------------------------------------------------------------
// itrs_checker
// Port-level assertions for the radix converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module itrs_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       o_stall,
    input wire       o_valid,
    input wire       i_stall,
    input wire [7:0] o_symbol,
    input wire       o_last
);

    // A stalled output beat holds its payload.
    `ITRS_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_symbol) && $stable(o_last)))

    // Once a number is taken the block stops taking numbers.
    `ITRS_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall)

    // While ready for a number, only the final beat of the previous one waits.
    `ITRS_ASSERT(a_idle_only_last, i_clk, i_rst_n, (o_valid && !o_stall) |-> o_last)

    // Reset empties the output and makes the block ready.
    `ITRS_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (!o_valid && !o_stall))

endmodule

bind integer_to_radix_symbols_core itrs_checker u_itrs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_symbol (o_symbol),
    .o_last   (o_last)
);

`default_nettype wire

### tb/sv/tb_integer_to_radix_symbols_core.sv
// ----------------------------------------------------------------------------
// tb_integer_to_radix_symbols_core
// Self-checking testbench for the signed integer to radix text converter.
// ----------------------------------------------------------------------------
// Numbers go in one beat at a time and the symbol beats that come out are
// compared against a behavioral predictor kept inside this file. The run
// covers directed corner cases (sign extremes, zero, the smallest and largest
// bases, unusable bases, ignored table entries, the unused register index),
// then random bases and numbers under several sender and receiver idling
// patterns, including a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_integer_to_radix_symbols_core;

    import itrs_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 4;
    // Worst item is base 2 with a sign and 32 digits.
    localparam int SETTLE_CYCLES  = 250;
    localparam int LONG_HOLD      = 600;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 64;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } t_sym_beat;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    t_cfg_index             i_cfg_index = CFG_SYMBOL_COUNT;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_valid     = 1'b0;
    logic [31:0]            i_number    = '0;
    logic                   i_stall     = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic [7:0]             o_symbol;
    logic                   o_last;

    // Idling controls shared between the stimulus and the receiver process.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_left      = 0;

    int errors      = 0;
    int idle_cycles = 0;

    // Symbol beats still owed by the converter, oldest first.
    t_sym_beat sym_expected[$];

    // Shadow copy of the configuration registers.
    logic [4:0]  radix_shadow = '0;
    logic [63:0] lo_shadow    = '0;
    logic [63:0] hi_shadow    = '0;

    integer_to_radix_symbols_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_number    (i_number),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_symbol    (o_symbol),
        .o_last      (o_last)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic logic [7:0] digit_symbol(input logic [31:0] idx);
        logic [127:0] tbl;
        tbl = {hi_shadow, lo_shadow};
        return tbl[8*idx[3:0] +: 8];
    endfunction

    // A base is usable only with 2..16 symbols, none of them zero, a sign
    // character, or a repeat of another symbol in use.
    function automatic bit base_usable();
        logic [7:0] s;
        if (radix_shadow < 2 || radix_shadow > MAX_SYMBOLS) return 1'b0;
        for (int a = 0; a < radix_shadow; a++) begin
            s = digit_symbol(a);
            if (s == 8'h00 || s == SYM_PLUS || s == SYM_MINUS) return 1'b0;
            for (int b = a + 1; b < radix_shadow; b++)
                if (digit_symbol(b) == s) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_symbols(input logic [31:0] num);
        logic [31:0] mag;
        logic [31:0] radix;
        logic [7:0]  digits[$];
        if (!base_usable()) return;
        radix = 32'(radix_shadow);
        if (num[31]) begin
            sym_expected.push_back('{SYM_MINUS, 1'b0});
            mag = -num;
        end else begin
            mag = num;
        end
        // Least significant digit is found first, so build the run backwards.
        do begin
            digits.push_front(digit_symbol(mag % radix));
            mag = mag / radix;
        end while (mag != 0);
        foreach (digits[k])
            sym_expected.push_back('{digits[k], k == digits.size() - 1});
    endfunction

    // ------------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------------

    // Offers one number and returns at the edge where it was taken. Valid is
    // left high so that a following call can stream without a bubble.
    task automatic send_number(input logic [31:0] num);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_number <= num;
        do @(posedge i_clk); while (o_stall);
        predict_symbols(num);
    endtask

    // Drops valid, waits for every owed beat, then gives the block time to
    // finish any number that produces no output.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sym_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after its last write.
    task automatic write_reg(input t_cfg_index idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SYMBOL_COUNT: radix_shadow = data[4:0];
            CFG_SYMBOLS_LOW:  lo_shadow    = data;
            CFG_SYMBOLS_HIGH: hi_shadow    = data;
            default: ;
        endcase
    endtask

    // The count register gets random upper bits, which must be ignored.
    task automatic load_base(input logic [4:0] count, input logic [127:0] tbl);
        write_reg(CFG_SYMBOL_COUNT, {$urandom, $urandom} & ~64'h1F | 64'(count));
        write_reg(CFG_SYMBOLS_LOW, tbl[63:0]);
        write_reg(CFG_SYMBOLS_HIGH, tbl[127:64]);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [127:0] text_table(input string s);
        logic [127:0] tbl;
        tbl = '0;
        for (int i = 0; i < s.len() && i < 16; i++) tbl[8*i +: 8] = s[i];
        return tbl;
    endfunction

    function automatic logic [31:0] random_number();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(5))
            0: return r;
            1: return $urandom_range(0, 99);
            2: return 32'd0 - $urandom_range(1, 99);
            3: begin
                case ($urandom_range(4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'd0;
                    default: return 32'd1;
                endcase
            end
            4: return {{16{r[15]}}, r[15:0]};
            default: return r >> $urandom_range(0, 31);
        endcase
    endfunction

    // Draws distinct usable symbols for the active entries and random junk for
    // the rest; one base in eight is then broken on purpose.
    task automatic load_random_base();
        logic [127:0] tbl;
        logic [4:0]   count;
        bit           taken[256];
        int           b;
        tbl = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(5))
            0:       count = 5'd2;
            1:       count = 5'd16;
            default: count = 5'($urandom_range(2, 16));
        endcase
        for (int i = 0; i < count; i++) begin
            do b = $urandom_range(255);
            while (b == 0 || b == SYM_PLUS || b == SYM_MINUS || taken[b]);
            taken[b] = 1'b1;
            tbl[8*i +: 8] = 8'(b);
        end
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0: tbl[8*$urandom_range(count - 1) +: 8] = 8'h00;
                1: tbl[8*(count - 1) +: 8] = tbl[7:0];
                2: count = 5'($urandom_range(0, 1));
                default: count = 5'($urandom_range(17, 31));
            endcase
        end
        load_base(count, tbl);
    endtask

    // ------------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_sym_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (sym_expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, got symbol %02h last %0b",
                         $time, o_symbol, o_last);
            end else begin
                want = sym_expected.pop_front();
                if (o_symbol !== want.symbol) begin
                    errors++;
                    $display("%0t: symbol mismatch, expected %02h, got %02h",
                             $time, want.symbol, o_symbol);
                end
                if (o_last !== want.last) begin
                    errors++;
                    $display("%0t: last mismatch, expected %0b, got %0b",
                             $time, want.last, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_decimal_extremes();
        wait_idle();
        load_base(5'd10, text_table("0123456789"));
        send_number(32'd0);
        send_number(32'd1);
        send_number(32'hFFFF_FFFF);
        send_number(32'h7FFF_FFFF);
        send_number(32'h8000_0000);
        send_number(32'd10);
        send_number(32'd0 - 32'd9);
    endtask

    // Base 2 gives the longest run: a minus sign and 32 digits for the
    // most negative value.
    task automatic test_binary_and_hex();
        wait_idle();
        load_base(5'd2, text_table("01"));
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        send_number(32'd5);
        wait_idle();
        load_base(5'd16, text_table("0123456789ABCDEF"));
        send_number(32'hFFFF_FFFF);
        send_number(32'h7FFF_FFFF);
    endtask

    // Entries past the count may hold zero, sign characters or repeats.
    task automatic test_unused_entries();
        logic [127:0] tbl;
        wait_idle();
        load_base(5'd3, text_table("xyz+-x"));
        send_number(32'h8000_0000);
        send_number(32'd8);
        wait_idle();
        tbl = text_table("0123456789ABCDEF");
        tbl[127:120] = "0";
        load_base(5'd15, tbl);
        send_number(32'hDEAD_BEEF);
    endtask

    task automatic check_invalid(input logic [4:0] count, input logic [127:0] tbl);
        wait_idle();
        load_base(count, tbl);
        send_number($urandom);
    endtask

    task automatic test_invalid_bases();
        logic [127:0] hex;
        logic [127:0] tbl;
        hex = text_table("0123456789ABCDEF");
        check_invalid(5'd0, hex);
        check_invalid(5'd1, hex);
        check_invalid(5'd17, hex);
        check_invalid(5'd31, hex);
        check_invalid(5'd4, text_table("01+3"));
        check_invalid(5'd2, text_table("0-"));
        tbl = hex;
        tbl[23:16] = 8'h00;
        check_invalid(5'd10, tbl);
        check_invalid(5'd4, text_table("0120"));
        tbl = hex;
        tbl[127:120] = "0";
        check_invalid(5'd16, tbl);
    endtask

    // A write to the spare index must leave the table alone.
    task automatic test_unused_index();
        wait_idle();
        load_base(5'd10, text_table("0123456789"));
        wait_idle();
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        send_number(32'd0 - 32'd12345);
    endtask

    // The receiver holds off long enough for the converter to back up and
    // stall the number channel while the sender keeps offering.
    task automatic test_long_hold();
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_base(5'd2, text_table("01"));
        hold_req = LONG_HOLD;
        repeat (8) send_number(random_number());
    endtask

    task automatic test_drain_pause();
        wait_idle();
        load_base(5'd10, text_table("0123456789"));
        repeat (5) send_number(random_number());
        wait_idle();
        repeat (5) send_number(random_number());
    endtask

    // Only numbers converted under a usable base count toward the phase.
    task automatic test_random(input int unsigned send_pct, input int unsigned stall_pct);
        int converted;
        converted = 0;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        while (converted < PHASE_ITEMS) begin
            wait_idle();
            load_random_base();
            repeat ($urandom_range(6, 16)) begin
                send_number(random_number());
                if (base_usable()) converted++;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_decimal_extremes();
        test_binary_and_hex();
        test_unused_entries();
        test_invalid_bases();
        test_unused_index();
        test_long_hold();
        test_drain_pause();
        test_random(0, 0);
        test_random(83, 0);
        test_random(0, 83);
        test_random(32, 32);

        wait_idle();
        if (sym_expected.size() != 0) errors++;
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### integer_to_radix_symbols_core.f
+incdir+rtl
rtl/itrs_pkg.sv
rtl/integer_to_radix_symbols_core.sv
rtl/itrs_checker.sv
tb/sv/tb_integer_to_radix_symbols_core.sv
